// ===== rtl/idiv_pkg.sv =====
// Shared types for the integer divider: controller commands and datapath status.
`timescale 1ns / 1ps

package idiv_pkg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // Capture operands and form magnitudes.
        logic step;   // One restoring shift and subtract.
        logic fix;    // Apply signs and special cases, update result registers.
    } t_idiv_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic last;   // The current step produces the final quotient bit.
    } t_idiv_sts;

endpackage

// ===== rtl/idiv_ctrl.sv =====
// Controller state machine for the integer divider.
`timescale 1ns / 1ps

module idiv_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    output logic                 o_valid,
    output idiv_pkg::t_idiv_cmd  o_cmd,
    input  idiv_pkg::t_idiv_sts  i_sts
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIX  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_valid;
    logic       w_accept;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign o_valid  = r_valid;

    assign o_cmd.load = w_accept;
    assign o_cmd.step = (r_state == S_RUN);
    assign o_cmd.fix  = (r_state == S_FIX);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (i_sts.last) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_FIX);
        end
    end

    // The result strobe follows the fix-up cycle and nothing else.
    a_valid_after_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIX) |=> o_valid)
        else $error("result strobe missing after fix-up");

    a_valid_only_after_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_FIX))
        else $error("result strobe without fix-up");

    // An accepted transfer starts the iteration in the next cycle.
    a_accept_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == S_RUN))
        else $error("accepted transfer did not start the divider");

    // The final step always leads into the fix-up cycle.
    a_last_to_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RUN) && i_sts.last) |=> (r_state == S_FIX))
        else $error("final step did not lead to fix-up");

endmodule

// ===== rtl/idiv_dp.sv =====
// Datapath of the integer divider: operand magnitudes, restoring iteration and sign fix-up.
`timescale 1ns / 1ps

module idiv_dp #(
    parameter int WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  idiv_pkg::t_idiv_cmd  i_cmd,
    output idiv_pkg::t_idiv_sts  o_sts,
    input  logic [WIDTH-1:0]     i_dividend,
    input  logic [WIDTH-1:0]     i_divisor,
    input  logic                 i_signed_mode,
    output logic [WIDTH-1:0]     o_quotient,
    output logic [WIDTH-1:0]     o_remainder,
    output logic                 o_divide_by_zero
);

    localparam int CNT_W = $clog2(WIDTH);

    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_quo;
    logic [WIDTH-1:0] r_div;
    logic             r_a_neg;
    logic             r_q_neg;
    logic             r_dz;
    logic [CNT_W-1:0] r_cnt;

    logic [WIDTH-1:0] r_q_out;
    logic [WIDTH-1:0] r_r_out;
    logic             r_dz_out;

    logic             w_a_neg;
    logic             w_b_neg;
    logic [WIDTH:0]   w_shift;
    logic [WIDTH:0]   w_trial;

    assign w_a_neg = i_signed_mode & i_dividend[WIDTH-1];
    assign w_b_neg = i_signed_mode & i_divisor[WIDTH-1];

    // The partial remainder stays below a nonzero divisor, so the shift fits in WIDTH+1 bits.
    assign w_shift = {r_rem, r_quo[WIDTH-1]};
    assign w_trial = w_shift - {1'b0, r_div};

    assign o_sts.last = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= CNT_W'(WIDTH - 1);
        end else if (i_cmd.step && (r_cnt != '0)) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem   <= '0;
            r_quo   <= w_a_neg ? (~i_dividend + 1'b1) : i_dividend;
            r_div   <= w_b_neg ? (~i_divisor + 1'b1) : i_divisor;
            r_a_neg <= w_a_neg;
            r_q_neg <= w_a_neg ^ w_b_neg;
            r_dz    <= (i_divisor == '0);
        end else if (i_cmd.step) begin
            if (!w_trial[WIDTH]) begin
                r_rem <= w_trial[WIDTH-1:0];
                r_quo <= {r_quo[WIDTH-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[WIDTH-1:0];
                r_quo <= {r_quo[WIDTH-2:0], 1'b0};
            end
        end
    end

    // With a zero divisor every trial succeeds, leaving the dividend magnitude in the
    // remainder; restoring its sign gives back the dividend.
    always_ff @(posedge i_clk) begin
        if (i_cmd.fix) begin
            r_q_out  <= r_dz ? '1 : (r_q_neg ? (~r_quo + 1'b1) : r_quo);
            r_r_out  <= r_a_neg ? (~r_rem + 1'b1) : r_rem;
            r_dz_out <= r_dz;
        end
    end

    assign o_quotient       = r_q_out;
    assign o_remainder      = r_r_out;
    assign o_divide_by_zero = r_dz_out;

endmodule

// ===== rtl/integer_divider_signed_unsigned.sv =====
// Top level of the signed/unsigned integer divider.
`timescale 1ns / 1ps

// Divides i_dividend by i_divisor at WIDTH bits, unsigned or, with i_signed_mode set, as
// two's complement truncating toward zero with the remainder taking the dividend's sign.
// A transfer is accepted at the rising edge at which start is high and busy is low, and
// that edge also loads the operand magnitudes. WIDTH steps of the single restoring
// shift-and-subtract unit follow, each yielding one quotient bit, then a sign fix-up
// state, and o_valid is high in the cycle after that. Quotient, remainder and
// o_divide_by_zero are valid for exactly the one cycle in which o_valid is high; the
// receiver cannot stall them, so it must take them then. A new transfer may be started in
// that same cycle; none is accepted while one is in progress. A zero divisor sets
// o_divide_by_zero, returns an all-ones quotient and a remainder equal to the dividend.
module integer_divider_signed_unsigned #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    input  logic             i_signed_mode,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_quotient,
    output logic [WIDTH-1:0] o_remainder,
    output logic             o_divide_by_zero
);

    idiv_pkg::t_idiv_cmd w_cmd;
    idiv_pkg::t_idiv_sts w_sts;

    idiv_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts)
    );

    idiv_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_dividend       (i_dividend),
        .i_divisor        (i_divisor),
        .i_signed_mode    (i_signed_mode),
        .o_quotient       (o_quotient),
        .o_remainder      (o_remainder),
        .o_divide_by_zero (o_divide_by_zero)
    );

endmodule

// ===== tb/integer_divider_signed_unsigned_tb.sv =====
// Self-checking testbench for the signed/unsigned integer divider.
`timescale 1ns / 1ps

module integer_divider_signed_unsigned_tb;

    localparam int W           = 32;
    localparam int RANDOM_OPS  = 650;
    localparam int STALL_LIMIT = 2000;

    localparam logic [W-1:0] ALL_ONES = {W{1'b1}};
    localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};

    localparam logic MODE_UNSIGNED = 1'b0;
    localparam logic MODE_SIGNED   = 1'b1;

    typedef struct {
        logic [W-1:0] quotient;
        logic [W-1:0] remainder;
        logic         div_zero;
    } t_quot_rem;

    class division_scoreboard;
        t_quot_rem pending_q[$];
        int        mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Truncating division; remainder follows the dividend's sign in signed mode.
        function t_quot_rem divide(logic [W-1:0] a, logic [W-1:0] b, logic mode);
            t_quot_rem res;
            logic [W-1:0] mag_a;
            logic [W-1:0] mag_b;
            logic         neg_a;
            logic         neg_b;
            res.div_zero = 1'b0;
            if (b == '0) begin
                res.quotient  = ALL_ONES;
                res.remainder = a;
                res.div_zero  = 1'b1;
            end else if (mode == MODE_UNSIGNED) begin
                res.quotient  = a / b;
                res.remainder = a % b;
            end else begin
                neg_a = a[W-1];
                neg_b = b[W-1];
                // The most negative value negates to itself, which is its magnitude unsigned.
                mag_a = neg_a ? -a : a;
                mag_b = neg_b ? -b : b;
                res.quotient  = mag_a / mag_b;
                res.remainder = mag_a % mag_b;
                if (neg_a != neg_b) begin
                    res.quotient = -res.quotient;
                end
                if (neg_a) begin
                    res.remainder = -res.remainder;
                end
            end
            return res;
        endfunction

        function void note_request(logic [W-1:0] a, logic [W-1:0] b, logic mode);
            pending_q.push_back(divide(a, b, mode));
        endfunction

        function void check_result(logic [W-1:0] q, logic [W-1:0] r, logic dz);
            t_quot_rem exp_res;
            if (pending_q.size() == 0) begin
                $error("result with no transfer outstanding: q=%h r=%h dz=%b", q, r, dz);
                mismatches++;
                return;
            end
            exp_res = pending_q.pop_front();
            if (q !== exp_res.quotient) begin
                $error("quotient: expected %h, actual %h", exp_res.quotient, q);
                mismatches++;
            end
            if (r !== exp_res.remainder) begin
                $error("remainder: expected %h, actual %h", exp_res.remainder, r);
                mismatches++;
            end
            if (dz !== exp_res.div_zero) begin
                $error("divide_by_zero: expected %b, actual %b", exp_res.div_zero, dz);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return pending_q.size();
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         start;
    logic         busy;
    logic [W-1:0] i_dividend;
    logic [W-1:0] i_divisor;
    logic         i_signed_mode;
    logic         o_valid;
    logic [W-1:0] o_quotient;
    logic [W-1:0] o_remainder;
    logic         o_divide_by_zero;

    division_scoreboard sb;
    int                 idle_cycles;

    integer_divider_signed_unsigned #(
        .WIDTH(W)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_dividend      (i_dividend),
        .i_divisor       (i_divisor),
        .i_signed_mode   (i_signed_mode),
        .o_valid         (o_valid),
        .o_quotient      (o_quotient),
        .o_remainder     (o_remainder),
        .o_divide_by_zero(o_divide_by_zero)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_division(logic [W-1:0] a, logic [W-1:0] b, logic mode);
        i_dividend    = a;
        i_divisor     = b;
        i_signed_mode = mode;
        start         = 1'b1;
        forever begin
            @(posedge i_clk);
            if (!busy) begin
                break;
            end
        end
        sb.note_request(a, b, mode);
        @(negedge i_clk);
    endtask

    task automatic pause_sender(int cycles);
        if (cycles > 0) begin
            start = 1'b0;
            repeat (cycles) @(negedge i_clk);
        end
    endtask

    // Biased operand: corner values, small magnitudes both signs, random widths, and full-range bits.
    function automatic logic [W-1:0] pick_operand();
        logic [W-1:0] val;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 5))
                    0: val = '0;
                    1: val = 1;
                    2: val = ALL_ONES;
                    3: val = MOST_NEG;
                    4: val = MOST_POS;
                    default: val = ALL_ONES - 1;
                endcase
            end
            1, 2: val = $urandom_range(0, 255);
            3: val = -$urandom_range(1, 255);
            4: val = $urandom >> $urandom_range(0, W - 1);
            5: val = -($urandom >> $urandom_range(0, W - 1));
            default: val = $urandom;
        endcase
        return val;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                sb.check_result(o_quotient, o_remainder, o_divide_by_zero);
            end
            if (o_valid || (start && !busy)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        logic [W-1:0] a;
        logic [W-1:0] b;
        int           sent;
        int           burst;
        int           max_gap;
        sb            = new();
        idle_cycles   = 0;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_dividend    = '0;
        i_divisor     = '0;
        i_signed_mode = MODE_UNSIGNED;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Divide by zero in both modes, including a negative dividend.
        send_division('0, '0, MODE_UNSIGNED);
        send_division(ALL_ONES, '0, MODE_UNSIGNED);
        send_division(MOST_NEG, '0, MODE_SIGNED);
        send_division(32'd12345, '0, MODE_SIGNED);
        // The one signed overflow case and its neighbors.
        send_division(MOST_NEG, ALL_ONES, MODE_SIGNED);
        send_division(MOST_NEG, 1, MODE_SIGNED);
        send_division(MOST_NEG, MOST_NEG, MODE_SIGNED);
        send_division(MOST_NEG, ALL_ONES, MODE_UNSIGNED);
        // Every sign combination with a nonzero remainder.
        send_division(7, -2, MODE_SIGNED);
        send_division(-7, 2, MODE_SIGNED);
        send_division(-7, -2, MODE_SIGNED);
        send_division(7, 2, MODE_SIGNED);
        send_division(-7, 2, MODE_UNSIGNED);
        // Range extremes.
        send_division(ALL_ONES, 1, MODE_UNSIGNED);
        send_division(ALL_ONES, ALL_ONES, MODE_UNSIGNED);
        send_division(1, ALL_ONES, MODE_UNSIGNED);
        send_division(ALL_ONES, ALL_ONES, MODE_SIGNED);
        send_division(MOST_POS, ALL_ONES, MODE_SIGNED);
        send_division(MOST_POS, MOST_NEG, MODE_SIGNED);
        send_division(MOST_POS, 3, MODE_SIGNED);
        send_division('0, ALL_ONES, MODE_SIGNED);
        send_division(5, 9, MODE_UNSIGNED);
        pause_sender(3);
        send_division(-5, 9, MODE_SIGNED);
        pause_sender(40);

        sent = 0;
        while (sent < RANDOM_OPS) begin
            burst   = $urandom_range(1, 24);
            // Some bursts run back to back; others leave gaps of varied length.
            max_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 45);
            repeat (burst) begin
                a = pick_operand();
                b = ($urandom_range(0, 24) == 0) ? '0 : pick_operand();
                send_division(a, b, 1'($urandom_range(0, 1)));
                sent++;
                if (max_gap > 0 && $urandom_range(0, 1) == 0) begin
                    pause_sender($urandom_range(1, max_gap));
                end
            end
            pause_sender($urandom_range(0, 60));
        end
        start = 1'b0;

        while (sb.outstanding() != 0) begin
            @(posedge i_clk);
        end
        repeat (W + 4) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== integer_divider_signed_unsigned.f =====
rtl/idiv_pkg.sv
rtl/idiv_ctrl.sv
rtl/idiv_dp.sv
rtl/integer_divider_signed_unsigned.sv
tb/integer_divider_signed_unsigned_tb.sv
